>>> rtl/ibba_pkg.sv
// Shared types and constants for the inode and block bitmap allocator.
// Holds function and status codes, field widths, sequencer states and the
// request and response structs of the shared word unit. No dependencies.
`timescale 1ns / 1ps

package ibba_pkg;

   localparam int FUNC_W    = 3;
   localparam int NUM_W     = 20;
   localparam int STATUS_W  = 2;
   localparam int ITOT_W    = 14;
   localparam int DTOT_W    = 16;
   localparam int WORD_W    = 32;
   localparam int BIDX_W    = 16;
   localparam int WIDX_W    = 11;
   localparam int CSR_W     = 20;
   localparam int CSR_IDX_W = 2;

   localparam logic [FUNC_W-1:0] FN_ALLOC_INODE = 3'd0;
   localparam logic [FUNC_W-1:0] FN_FREE_INODE  = 3'd1;
   localparam logic [FUNC_W-1:0] FN_ALLOC_BLOCK = 3'd2;
   localparam logic [FUNC_W-1:0] FN_FREE_BLOCK  = 3'd3;
   localparam logic [FUNC_W-1:0] FN_FORMAT      = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_INODE_TOTAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_FIRST  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_TOTAL  = 2'd2;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE
   } ctrl_state_type;

   typedef enum logic {
      UOP_FIND,
      UOP_CLEAR
   } unit_op_type;

   typedef struct packed {
      unit_op_type         op;
      logic [WORD_W-1:0]   rd_word;
      logic [WIDX_W-1:0]   word;
      logic [4:0]          bit_sel;
      logic [BIDX_W-1:0]   limit;
      logic                skip_zero;
   } unit_req_type;

   typedef struct packed {
      logic                found;
      logic [4:0]          pos;
      logic                last;
      logic [WORD_W-1:0]   new_word;
   } unit_rsp_type;

endpackage

>>> rtl/inode_and_block_bitmap_allocator.sv
// Top level of the inode and block bitmap allocator: configuration
// registers, effective counts, sequencer and shared word unit.
// Depends on ibba_pkg, ibba_ctrl, ibba_scan_unit.
`timescale 1ns / 1ps

// Usage:
//   Command channel: drive req_func and req_item_number with start high; the
//   item is taken at an edge where start is high and busy is low. busy stays
//   high until the block can take the next item.
//   Result channel: rsp_valid pulses for one cycle with rsp_granted_number
//   and rsp_status; one result per item. The receiver cannot stall it.
//   Configuration: csr_we with csr_index and csr_wdata writes a register
//   (0 inode_total, 1 data_first_block, 2 data_block_total); write only
//   while busy is low and no result is pending.
//   Path from accept to rsp_valid:
//     range error, unknown code, allocate at zero free count: next cycle
//     free: bitmap word read, then S_FREE writes it back
//     allocate: one S_SCAN step per bitmap word scanned; the single read
//       port of each bitmap memory examines one 32-bit word per cycle
//     format: a sweep of W words, W = larger of INODE_BITS/32 and DATA_BITS/32
//   Reset: a clearing pass over W words zeroes both bitmaps while busy is
//   high; configuration writes are taken during it. Format must come first.
module inode_and_block_bitmap_allocator #(
   parameter int INODE_BITS = 8192,
   parameter int DATA_BITS  = 32768
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ibba_pkg::FUNC_W-1:0]       req_func,
   input  logic [ibba_pkg::NUM_W-1:0]        req_item_number,
   output logic                              rsp_valid,
   output logic [ibba_pkg::NUM_W-1:0]        rsp_granted_number,
   output logic [ibba_pkg::STATUS_W-1:0]     rsp_status,
   input  logic                              csr_we,
   input  logic [ibba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ibba_pkg::CSR_W-1:0]        csr_wdata
);
   import ibba_pkg::*;

   localparam int INODE_WORDS = (INODE_BITS + 31) / 32;
   localparam int DATA_WORDS  = (DATA_BITS + 31) / 32;

   logic [ITOT_W-1:0] inode_total_ff, inode_total_in;
   logic [NUM_W-1:0]  data_first_ff, data_first_in;
   logic [DTOT_W-1:0] data_total_ff, data_total_in;
   logic [ITOT_W-1:0] eff_inodes;
   logic [DTOT_W-1:0] eff_blocks;
   unit_req_type      unit_req;
   unit_rsp_type      unit_rsp;

   always_comb begin
      inode_total_in = inode_total_ff;
      data_first_in  = data_first_ff;
      data_total_in  = data_total_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_INODE_TOTAL: inode_total_in = csr_wdata[ITOT_W-1:0];
            CSR_DATA_FIRST:  data_first_in  = csr_wdata[NUM_W-1:0];
            CSR_DATA_TOTAL:  data_total_in  = csr_wdata[DTOT_W-1:0];
            default:         inode_total_in = inode_total_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inode_total_ff <= 14'd8192;
         data_first_ff  <= 20'd1;
         data_total_ff  <= 16'd0;
      end else begin
         inode_total_ff <= inode_total_in;
         data_first_ff  <= data_first_in;
         data_total_ff  <= data_total_in;
      end
   end

   assign eff_inodes = (32'(inode_total_ff) < INODE_BITS) ? inode_total_ff
                                                           : ITOT_W'(INODE_BITS);
   assign eff_blocks = (32'(data_total_ff) < DATA_BITS) ? data_total_ff
                                                         : DTOT_W'(DATA_BITS);

   ibba_ctrl #(
      .INODE_WORDS (INODE_WORDS),
      .DATA_WORDS  (DATA_WORDS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_item_number    (req_item_number),
      .eff_inodes         (eff_inodes),
      .eff_blocks         (eff_blocks),
      .data_first         (data_first_ff),
      .unit_req           (unit_req),
      .unit_rsp           (unit_rsp),
      .rsp_valid          (rsp_valid),
      .rsp_granted_number (rsp_granted_number),
      .rsp_status         (rsp_status)
   );

   ibba_scan_unit u_scan_unit (
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );

endmodule

>>> rtl/ibba_ram.sv
// Single write port, single registered read port bitmap memory.
// Depends on ibba_pkg for the word width.
`timescale 1ns / 1ps

module ibba_ram #(
   parameter int DEPTH = 256
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [ibba_pkg::WORD_W-1:0]   wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [ibba_pkg::WORD_W-1:0]   rd_data
);
   import ibba_pkg::*;

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ibba_scan_unit.sv
// Shared word unit: masks one bitmap word to the valid index window, finds
// its lowest clear bit, and builds the updated word for set or clear.
// Depends on ibba_pkg for the request and response structs.
`timescale 1ns / 1ps

module ibba_scan_unit (
   input  ibba_pkg::unit_req_type unit_req,
   output ibba_pkg::unit_rsp_type unit_rsp
);
   import ibba_pkg::*;

   logic [BIDX_W:0]   rem;
   logic [WORD_W-1:0] mask;
   logic [WORD_W-1:0] cand;
   logic [WORD_W-1:0] low;
   logic [WORD_W-1:0] clr;
   logic [4:0]        pos;

   always_comb begin
      rem = {1'b0, unit_req.limit} - {1'b0, unit_req.word, 5'b0};
      if (rem >= 17'd32) begin
         mask = '1;
      end else begin
         mask = (32'h1 << rem[4:0]) - 32'h1;
      end
      if (unit_req.skip_zero && unit_req.word == '0) begin
         mask[0] = 1'b0;
      end
      cand = ~unit_req.rd_word & mask;
      low  = cand & (~cand + 32'h1);
      pos  = '0;
      for (int j = 0; j < WORD_W; j++) begin
         if (low[j]) begin
            pos = pos | 5'(j);
         end
      end
      clr = ~(32'h1 << unit_req.bit_sel);

      unit_rsp.found = |cand;
      unit_rsp.pos   = pos;
      unit_rsp.last  = (rem <= 17'd32);
      if (unit_req.op == UOP_FIND) begin
         unit_rsp.new_word = unit_req.rd_word | low;
      end else begin
         unit_rsp.new_word = unit_req.rd_word & clr;
      end
   end

endmodule

>>> rtl/ibba_ctrl.sv
// Sequencer: clearing sweep, word scan, free read-modify-write, counters.
// Holds both bitmap memories; depends on ibba_pkg, ibba_ram, and drives
// the shared word unit through its structs.
`timescale 1ns / 1ps

module ibba_ctrl #(
   parameter int INODE_WORDS = 256,
   parameter int DATA_WORDS  = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ibba_pkg::FUNC_W-1:0]       req_func,
   input  logic [ibba_pkg::NUM_W-1:0]        req_item_number,
   input  logic [ibba_pkg::ITOT_W-1:0]       eff_inodes,
   input  logic [ibba_pkg::DTOT_W-1:0]       eff_blocks,
   input  logic [ibba_pkg::NUM_W-1:0]        data_first,
   output ibba_pkg::unit_req_type            unit_req,
   input  ibba_pkg::unit_rsp_type            unit_rsp,
   output logic                              rsp_valid,
   output logic [ibba_pkg::NUM_W-1:0]        rsp_granted_number,
   output logic [ibba_pkg::STATUS_W-1:0]     rsp_status
);
   import ibba_pkg::*;

   localparam int IAW  = $clog2(INODE_WORDS);
   localparam int DAW  = $clog2(DATA_WORDS);
   localparam int MAXW = (INODE_WORDS > DATA_WORDS) ? INODE_WORDS : DATA_WORDS;
   localparam int SWW  = $clog2(MAXW);

   ctrl_state_type      state_ff, state_in;
   logic [WIDX_W-1:0]   word_ff, word_in;
   logic [BIDX_W-1:0]   bidx_ff, bidx_in;
   logic                sel_data_ff, sel_data_in;
   logic                fmt_ff, fmt_in;
   logic [SWW-1:0]      sweep_ff, sweep_in;
   logic [ITOT_W-1:0]   icnt_ff, icnt_in;
   logic [DTOT_W-1:0]   bcnt_ff, bcnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0]    rsp_num_ff, rsp_num_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic              i_wr_en, i_rd_en, d_wr_en, d_rd_en;
   logic [IAW-1:0]    i_wr_addr, i_rd_addr;
   logic [DAW-1:0]    d_wr_addr, d_rd_addr;
   logic [WORD_W-1:0] i_wr_data, i_rd_data, d_wr_data, d_rd_data;

   logic              sweep_last;
   logic [NUM_W-1:0]  blk_off;
   logic              inode_bad, block_bad;
   logic [WIDX_W-1:0] word_nxt;
   logic [BIDX_W-1:0] found_idx;

   ibba_ram #(.DEPTH(INODE_WORDS)) u_inode_ram (
      .clock   (clock),
      .wr_en   (i_wr_en),
      .wr_addr (i_wr_addr),
      .wr_data (i_wr_data),
      .rd_en   (i_rd_en),
      .rd_addr (i_rd_addr),
      .rd_data (i_rd_data)
   );

   ibba_ram #(.DEPTH(DATA_WORDS)) u_data_ram (
      .clock   (clock),
      .wr_en   (d_wr_en),
      .wr_addr (d_wr_addr),
      .wr_data (d_wr_data),
      .rd_en   (d_rd_en),
      .rd_addr (d_rd_addr),
      .rd_data (d_rd_data)
   );

   assign sweep_last = (sweep_ff == SWW'(MAXW - 1));
   assign blk_off    = req_item_number - data_first;
   assign inode_bad  = (req_item_number == '0) ||
                       (req_item_number >= {6'b0, eff_inodes});
   assign block_bad  = (req_item_number < data_first) ||
                       (blk_off >= {4'b0, eff_blocks});
   assign word_nxt   = word_ff + 11'd1;
   assign found_idx  = {word_ff, unit_rsp.pos};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               unique case (req_func)
                  FN_ALLOC_INODE: if (icnt_ff != '0) state_in = S_SCAN;
                  FN_FREE_INODE:  if (!inode_bad) state_in = S_FREE;
                  FN_ALLOC_BLOCK: if (bcnt_ff != '0) state_in = S_SCAN;
                  FN_FREE_BLOCK:  if (!block_bad) state_in = S_FREE;
                  FN_FORMAT:      state_in = S_CLEAR;
                  default:        state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (unit_rsp.found || unit_rsp.last) begin
               state_in = S_IDLE;
            end
         end
         S_FREE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      word_in       = word_ff;
      bidx_in       = bidx_ff;
      sel_data_in   = sel_data_ff;
      fmt_in        = fmt_ff;
      sweep_in      = sweep_ff;
      icnt_in       = icnt_ff;
      bcnt_in       = bcnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_num_in    = '0;
      rsp_status_in = ST_OK;
      i_wr_en       = 1'b0;
      i_wr_addr     = IAW'(word_ff);
      i_wr_data     = unit_rsp.new_word;
      i_rd_en       = 1'b0;
      i_rd_addr     = IAW'(word_nxt);
      d_wr_en       = 1'b0;
      d_wr_addr     = DAW'(word_ff);
      d_wr_data     = unit_rsp.new_word;
      d_rd_en       = 1'b0;
      d_rd_addr     = DAW'(word_nxt);

      unit_req.op        = (state_ff == S_FREE) ? UOP_CLEAR : UOP_FIND;
      unit_req.rd_word   = sel_data_ff ? d_rd_data : i_rd_data;
      unit_req.word      = (state_ff == S_FREE) ? bidx_ff[BIDX_W-1:5] : word_ff;
      unit_req.bit_sel   = bidx_ff[4:0];
      unit_req.limit     = sel_data_ff ? eff_blocks : {2'b0, eff_inodes};
      unit_req.skip_zero = !sel_data_ff;

      unique case (state_ff)
         S_CLEAR: begin
            i_wr_en   = (32'(sweep_ff) < INODE_WORDS);
            i_wr_addr = IAW'(sweep_ff);
            i_wr_data = (fmt_ff && sweep_ff == '0) ? 32'h3 : '0;
            d_wr_en   = (32'(sweep_ff) < DATA_WORDS);
            d_wr_addr = DAW'(sweep_ff);
            d_wr_data = '0;
            sweep_in  = SWW'(sweep_ff + 1'b1);
            if (sweep_last) begin
               sweep_in = '0;
               if (fmt_ff) begin
                  fmt_in        = 1'b0;
                  icnt_in       = (eff_inodes >= 14'd2) ? eff_inodes - 14'd2 : '0;
                  bcnt_in       = eff_blocks;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_OK;
               end
            end
         end
         S_IDLE: begin
            if (start) begin
               unique case (req_func)
                  FN_ALLOC_INODE: begin
                     sel_data_in = 1'b0;
                     word_in     = '0;
                     i_rd_addr   = '0;
                     if (icnt_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOSPACE;
                     end else begin
                        i_rd_en = 1'b1;
                     end
                  end
                  FN_FREE_INODE: begin
                     sel_data_in = 1'b0;
                     bidx_in     = req_item_number[BIDX_W-1:0];
                     i_rd_addr   = IAW'(req_item_number[BIDX_W-1:5]);
                     if (inode_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end else begin
                        i_rd_en = 1'b1;
                     end
                  end
                  FN_ALLOC_BLOCK: begin
                     sel_data_in = 1'b1;
                     word_in     = '0;
                     d_rd_addr   = '0;
                     if (bcnt_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOSPACE;
                     end else begin
                        d_rd_en = 1'b1;
                     end
                  end
                  FN_FREE_BLOCK: begin
                     sel_data_in = 1'b1;
                     bidx_in     = blk_off[BIDX_W-1:0];
                     d_rd_addr   = DAW'(blk_off[BIDX_W-1:5]);
                     if (block_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end else begin
                        d_rd_en = 1'b1;
                     end
                  end
                  FN_FORMAT: begin
                     fmt_in   = 1'b1;
                     sweep_in = '0;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (unit_rsp.found) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               if (sel_data_ff) begin
                  d_wr_en    = 1'b1;
                  bcnt_in    = bcnt_ff - 16'd1;
                  rsp_num_in = data_first + {4'b0, found_idx};
               end else begin
                  i_wr_en    = 1'b1;
                  icnt_in    = icnt_ff - 14'd1;
                  rsp_num_in = {4'b0, found_idx};
               end
            end else if (unit_rsp.last) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOSPACE;
            end else begin
               word_in = word_nxt;
               i_rd_en = !sel_data_ff;
               d_rd_en = sel_data_ff;
            end
         end
         S_FREE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            i_wr_addr     = IAW'(bidx_ff[BIDX_W-1:5]);
            d_wr_addr     = DAW'(bidx_ff[BIDX_W-1:5]);
            if (sel_data_ff) begin
               d_wr_en = 1'b1;
               if (bcnt_ff != '1) begin
                  bcnt_in = bcnt_ff + 16'd1;
               end
            end else begin
               i_wr_en = 1'b1;
               if (icnt_ff != '1) begin
                  icnt_in = icnt_ff + 14'd1;
               end
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         fmt_ff       <= 1'b0;
         icnt_ff      <= '0;
         bcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         fmt_ff       <= fmt_in;
         icnt_ff      <= icnt_in;
         bcnt_ff      <= bcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      bidx_ff       <= bidx_in;
      sel_data_ff   <= sel_data_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_number = rsp_num_ff;
   assign rsp_status         = rsp_status_ff;

   a_rsp_only_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_IDLE)
      else $error("response strobe outside idle");

   a_alloc_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start && req_func == FN_ALLOC_INODE && icnt_ff != '0)
      |=> state_ff == S_SCAN)
      else $error("inode allocation did not start a scan");

   a_grant_decrements: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && !sel_data_ff && unit_rsp.found)
      |=> icnt_ff == $past(icnt_ff) - 14'd1)
      else $error("inode grant did not decrement free count");

   a_scan_ends_in_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && (unit_rsp.found || unit_rsp.last)) |=> rsp_valid_ff)
      else $error("finished scan gave no response");

endmodule
